// ===== src/corner_cell_usage_tracker_defines.svh =====
// Assertion helpers shared by the tracker RTL.
`ifndef CORNER_CELL_USAGE_TRACKER_DEFINES_SVH
`define CORNER_CELL_USAGE_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCUT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccut: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CCUT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccut: next-cycle check failed");

`endif

// ===== src/ccut_pkg.sv =====
package ccut_pkg;

   localparam int MAX_RADIUS_DEF = 15;

   localparam int REQ_W    = 2;
   localparam int COORD_W  = 26;
   localparam int SIZE_W   = 13;
   localparam int ENTRY_W  = 10;
   localparam int MARKS_W  = 3;
   localparam int TOTAL_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int RADIUS_W = 4;
   // cell centre needs one bit more than a quarter of the coordinate range
   localparam int CENTER_W = 25;
   localparam int REL_W    = 27;

   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
   localparam logic [REQ_W-1:0] REQ_AREA  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_CALC,
      S_READ,
      S_UPD,
      S_RDMEM,
      S_RDOUT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic               we;
      logic               mark;
      logic               count_we;
      logic [COUNT_W-1:0] count;
   } mem_wr_type;

endpackage

// ===== src/corner_cell_usage_tracker.sv =====
// Corner cell usage tracker.
// Request channel: drive start with the req_ fields; a request is taken at a
// clock edge where start is high and busy is low. Each request gives exactly
// one result, shown on the rsp_ ports for one cycle with rsp_strobe high.
// The receiver cannot stall; results are never held back.
// Configuration: csr_track_radius is written when csr_valid and csr_ready are
// both high; csr_ready is high only while idle with no start pending. A
// nonzero radius clears all counts, which runs a sweep of one cell per cycle.
// Request steps: a query takes one address step per corner, plus a memory
// read for each corner inside the window and a write when that cell is not
// yet marked; an entry read takes a memory read, or none outside the window;
// a new area first sweeps its marks clear only when the previous area saw
// usage and is closed; radius zero or an unused type answers directly. All
// four corners go through one address unit and one single-port cell memory,
// one at a time. Busy drops the cycle after the strobe, so a new request is
// taken only after the previous one has given its result.
// Reset: synchronous; afterwards the block sweeps all DEPTH cells of the cell
// memory clear ((2*MAX_RADIUS+1)^2, 961 by default), with busy held high.
`include "corner_cell_usage_tracker_defines.svh"

module corner_cell_usage_tracker #(
   parameter int MAX_RADIUS = ccut_pkg::MAX_RADIUS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ccut_pkg::REQ_W-1:0]          req_type,
   input  logic signed [ccut_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [ccut_pkg::COORD_W-1:0] req_coord_z,
   input  logic [ccut_pkg::SIZE_W-1:0]         req_area_width,
   input  logic [ccut_pkg::SIZE_W-1:0]         req_area_depth,
   input  logic [ccut_pkg::ENTRY_W-1:0]        req_entry_index,
   output logic                                rsp_strobe,
   output logic [ccut_pkg::MARKS_W-1:0]        rsp_new_marks,
   output logic [ccut_pkg::TOTAL_W-1:0]        rsp_unique_total,
   output logic [ccut_pkg::TOTAL_W-1:0]        rsp_areas_total,
   output logic [ccut_pkg::COUNT_W-1:0]        rsp_entry_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ccut_pkg::RADIUS_W-1:0]       csr_track_radius
);

   localparam int DEPTH  = (2*MAX_RADIUS+1) * (2*MAX_RADIUS+1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RW     = $clog2(MAX_RADIUS+1);
   localparam int CW     = (RW > ccut_pkg::RADIUS_W) ? RW : ccut_pkg::RADIUS_W;
   localparam int SQ_W   = 2 * (RW + 1);
   localparam int EW     = (SQ_W > ccut_pkg::ENTRY_W) ? SQ_W : ccut_pkg::ENTRY_W;
   localparam int RELW   = ccut_pkg::REL_W;
   localparam int CTRW   = ccut_pkg::CENTER_W;
   localparam int SUMW   = ccut_pkg::COORD_W + 2;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   // control state
   ccut_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                clr_all_ff, clr_all_in;
   logic                clr_resp_ff, clr_resp_in;
   logic [ccut_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [ccut_pkg::TOTAL_W-1:0]  unique_ff, unique_in;
   logic [ccut_pkg::TOTAL_W-1:0]  area_ff, area_in;
   logic                has_usage_ff, has_usage_in;
   logic signed [CTRW-1:0] center_x_ff, center_x_in;
   logic signed [CTRW-1:0] center_z_ff, center_z_in;

   // per-request working registers
   logic signed [RELW-1:0] rel_x_ff, rel_x_in;
   logic signed [RELW-1:0] rel_z_ff, rel_z_in;
   logic [1:0]             corner_ff, corner_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [ccut_pkg::MARKS_W-1:0] marks_ff, marks_in;
   logic [ccut_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ccut_pkg::ENTRY_W-1:0] entry_ff, entry_in;

   // cell memory port
   logic [ADDR_W-1:0]            mem_addr;
   ccut_pkg::mem_wr_type         mem_wr;
   logic                         mark_rd;
   logic [ccut_pkg::COUNT_W-1:0] count_rd;

   // window geometry
   logic [CW-1:0]   radius_cmp;
   logic [RW-1:0]   eff_r;
   logic [RW:0]     side;
   logic [RW:0]     two_r;
   logic [SQ_W-1:0] side_sq;
   logic            entry_fits;

   // shared address unit
   logic signed [RELW-1:0] dx_off, dz_off, two_r_s;
   logic            in_win;
   logic [SQ_W-1:0] row_base;
   logic [ADDR_W-1:0] calc_idx;

   // request decode helpers
   logic signed [SUMW-1:0] sum_x, sum_z;
   logic            area_ok;

   logic req_take;
   logic csr_take;

   ccut_cell_mem #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_mem (
      .clock    (clock),
      .addr     (mem_addr),
      .wr       (mem_wr),
      .mark_rd  (mark_rd),
      .count_rd (count_rd)
   );

   // handshakes
   assign busy      = (state_ff != ccut_pkg::S_IDLE);
   assign csr_ready = (state_ff == ccut_pkg::S_IDLE) && !start;
   assign req_take  = start && !busy;
   assign csr_take  = csr_valid && csr_ready;

   // results come straight from the working registers
   assign rsp_strobe       = (state_ff == ccut_pkg::S_RESP);
   assign rsp_new_marks    = marks_ff;
   assign rsp_unique_total = unique_ff;
   assign rsp_areas_total  = area_ff;
   assign rsp_entry_count  = count_ff;

   // saturate the programmed radius to the window the memory holds
   assign radius_cmp = CW'(radius_ff);
   assign eff_r      = (radius_cmp > CW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_cmp);
   assign side       = {eff_r, 1'b1};
   assign two_r      = {eff_r, 1'b0};
   assign side_sq    = SQ_W'(side) * SQ_W'(side);
   assign entry_fits = (EW'(req_entry_index) < EW'(side_sq));

   // offset of the current corner from the window's low edge; the corner
   // code's high bit steps x, its low bit steps z
   assign two_r_s  = $signed(RELW'(two_r));
   assign dx_off   = rel_x_ff + $signed(RELW'(corner_ff[1])) + $signed(RELW'(eff_r));
   assign dz_off   = rel_z_ff + $signed(RELW'(corner_ff[0])) + $signed(RELW'(eff_r));
   assign in_win   = !dx_off[RELW-1] && (dx_off <= two_r_s)
                  && !dz_off[RELW-1] && (dz_off <= two_r_s);
   assign row_base = SQ_W'(dz_off[RW:0]) * SQ_W'(side);
   assign calc_idx = ADDR_W'(row_base + SQ_W'(dx_off[RW:0]));

   // doubled corner plus extent, floored by eight, gives the centre cell
   assign sum_x   = (SUMW'(req_coord_x) <<< 1) + $signed(SUMW'(req_area_width));
   assign sum_z   = (SUMW'(req_coord_z) <<< 1) + $signed(SUMW'(req_area_depth));
   assign area_ok = (req_area_width != '0) && (req_area_depth != '0);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_all_in   = clr_all_ff;
      clr_resp_in  = clr_resp_ff;
      radius_in    = radius_ff;
      unique_in    = unique_ff;
      area_in      = area_ff;
      has_usage_in = has_usage_ff;
      center_x_in  = center_x_ff;
      center_z_in  = center_z_ff;
      rel_x_in     = rel_x_ff;
      rel_z_in     = rel_z_ff;
      corner_in    = corner_ff;
      idx_in       = idx_ff;
      marks_in     = marks_ff;
      count_in     = count_ff;
      entry_in     = entry_ff;
      mem_addr     = idx_ff;
      mem_wr       = '0;

      unique case (state_ff)
         ccut_pkg::S_IDLE: begin
            if (csr_take) begin
               radius_in = csr_track_radius;
               // a nonzero radius starts a fresh tracking run
               if (csr_track_radius != '0) begin
                  unique_in    = '0;
                  area_in      = '0;
                  has_usage_in = 1'b0;
                  clr_cnt_in   = '0;
                  clr_all_in   = 1'b1;
                  clr_resp_in  = 1'b0;
                  state_in     = ccut_pkg::S_CLEAR;
               end
            end else if (req_take) begin
               marks_in = '0;
               count_in = '0;
               state_in = ccut_pkg::S_RESP;
               if (eff_r != '0) begin
                  unique case (req_type)
                     ccut_pkg::REQ_QUERY: begin
                        rel_x_in  = RELW'(req_coord_x >>> 2) - RELW'(center_x_ff);
                        rel_z_in  = RELW'(req_coord_z >>> 2) - RELW'(center_z_ff);
                        corner_in = '0;
                        state_in  = ccut_pkg::S_CALC;
                     end
                     ccut_pkg::REQ_AREA: begin
                        if (area_ok) begin
                           center_x_in = CTRW'(sum_x >>> 3);
                           center_z_in = CTRW'(sum_z >>> 3);
                           // close the previous area only if it saw usage
                           if (has_usage_ff) begin
                              if (area_ff != '1) begin
                                 area_in = area_ff + 1'b1;
                              end
                              has_usage_in = 1'b0;
                              clr_cnt_in   = '0;
                              clr_all_in   = 1'b0;
                              clr_resp_in  = 1'b1;
                              state_in     = ccut_pkg::S_CLEAR;
                           end
                        end
                     end
                     ccut_pkg::REQ_READ: begin
                        if (entry_fits) begin
                           entry_in = req_entry_index;
                           state_in = ccut_pkg::S_RDMEM;
                        end
                     end
                     default: begin
                        state_in = ccut_pkg::S_RESP;
                     end
                  endcase
               end
            end
         end

         ccut_pkg::S_CLEAR: begin
            // sweep one cell per cycle; counts only on a full clear
            mem_addr        = clr_cnt_ff;
            mem_wr.we       = 1'b1;
            mem_wr.mark     = 1'b0;
            mem_wr.count_we = clr_all_ff;
            mem_wr.count    = '0;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = clr_resp_ff ? ccut_pkg::S_RESP : ccut_pkg::S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         ccut_pkg::S_CALC: begin
            if (in_win) begin
               idx_in   = calc_idx;
               state_in = ccut_pkg::S_READ;
            end else if (corner_ff == 2'd3) begin
               state_in = ccut_pkg::S_RESP;
            end else begin
               corner_in = corner_ff + 1'b1;
            end
         end

         ccut_pkg::S_READ: begin
            mem_addr = idx_ff;
            state_in = ccut_pkg::S_UPD;
         end

         ccut_pkg::S_UPD: begin
            mem_addr = idx_ff;
            if (!mark_rd) begin
               mem_wr.we       = 1'b1;
               mem_wr.mark     = 1'b1;
               mem_wr.count_we = 1'b1;
               mem_wr.count    = (count_rd != '1) ? count_rd + 1'b1 : count_rd;
               if (unique_ff != '1) begin
                  unique_in = unique_ff + 1'b1;
               end
               has_usage_in = 1'b1;
               marks_in     = marks_ff + 1'b1;
            end
            if (corner_ff == 2'd3) begin
               state_in = ccut_pkg::S_RESP;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in  = ccut_pkg::S_CALC;
            end
         end

         ccut_pkg::S_RDMEM: begin
            mem_addr = ADDR_W'(entry_ff);
            state_in = ccut_pkg::S_RDOUT;
         end

         ccut_pkg::S_RDOUT: begin
            count_in = count_rd;
            state_in = ccut_pkg::S_RESP;
         end

         ccut_pkg::S_RESP: begin
            state_in = ccut_pkg::S_IDLE;
         end

         default: begin
            state_in = ccut_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccut_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_all_ff   <= 1'b1;
         clr_resp_ff  <= 1'b0;
         radius_ff    <= '0;
         unique_ff    <= '0;
         area_ff      <= '0;
         has_usage_ff <= 1'b0;
         center_x_ff  <= '0;
         center_z_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_all_ff   <= clr_all_in;
         clr_resp_ff  <= clr_resp_in;
         radius_ff    <= radius_in;
         unique_ff    <= unique_in;
         area_ff      <= area_in;
         has_usage_ff <= has_usage_in;
         center_x_ff  <= center_x_in;
         center_z_ff  <= center_z_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_x_ff  <= rel_x_in;
      rel_z_ff  <= rel_z_in;
      corner_ff <= corner_in;
      idx_ff    <= idx_in;
      marks_ff  <= marks_in;
      count_ff  <= count_in;
      entry_ff  <= entry_in;
   end

   // the strobe lasts one cycle
   `CCUT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   // a taken request always sets busy in the cycle after it is taken
   `CCUT_ASSERT_NEXT(a_take_busy, clock, reset, req_take, busy)
   // a count is only bumped on a cell not yet marked in this area
   `CCUT_ASSERT_SAME(a_first_use, clock, reset,
      (state_ff == ccut_pkg::S_UPD) && mem_wr.count_we, !mark_rd)
   // a nonzero radius write starts a full sweep from the first cell
   `CCUT_ASSERT_NEXT(a_cfg_sweep, clock, reset, csr_take && (csr_track_radius != '0),
      (state_ff == ccut_pkg::S_CLEAR) && (clr_cnt_ff == '0) && clr_all_ff)

endmodule

// ===== src/ccut_cell_mem.sv =====
module ccut_cell_mem #(
   parameter int MAX_RADIUS = ccut_pkg::MAX_RADIUS_DEF
) (
   input  logic                             clock,
   input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0] addr,
   input  ccut_pkg::mem_wr_type             wr,
   output logic                             mark_rd,
   output logic [ccut_pkg::COUNT_W-1:0]     count_rd
);

   localparam int DEPTH = (2*MAX_RADIUS+1) * (2*MAX_RADIUS+1);

   logic                         mark_mem  [DEPTH];
   logic [ccut_pkg::COUNT_W-1:0] count_mem [DEPTH];

   // single port: write and registered read share the address
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mark_mem[addr] <= wr.mark;
      end
      if (wr.count_we) begin
         count_mem[addr] <= wr.count;
      end
      mark_rd  <= mark_mem[addr];
      count_rd <= count_mem[addr];
   end

endmodule
